@@ rtl/core/rsm_pkg.sv @@
// Shared types and constants for the register stack machine executor.
// Opcodes, fault codes, controller states, datapath commands and status.
// No dependencies.
package rsm_pkg;

  localparam logic [4:0] OP_LIT   = 5'd1;
  localparam logic [4:0] OP_RTN   = 5'd2;
  localparam logic [4:0] OP_LOD   = 5'd3;
  localparam logic [4:0] OP_STO   = 5'd4;
  localparam logic [4:0] OP_CAL   = 5'd5;
  localparam logic [4:0] OP_INC   = 5'd6;
  localparam logic [4:0] OP_JMP   = 5'd7;
  localparam logic [4:0] OP_JPC   = 5'd8;
  localparam logic [4:0] OP_WRITE = 5'd9;
  localparam logic [4:0] OP_READ  = 5'd10;
  localparam logic [4:0] OP_HALT  = 5'd11;
  localparam logic [4:0] OP_NEG   = 5'd12;
  localparam logic [4:0] OP_ADD   = 5'd13;
  localparam logic [4:0] OP_SUB   = 5'd14;
  localparam logic [4:0] OP_MUL   = 5'd15;
  localparam logic [4:0] OP_DIV   = 5'd16;
  localparam logic [4:0] OP_ODD   = 5'd17;
  localparam logic [4:0] OP_MOD   = 5'd18;
  localparam logic [4:0] OP_EQL   = 5'd19;
  localparam logic [4:0] OP_NEQ   = 5'd20;
  localparam logic [4:0] OP_LSS   = 5'd21;
  localparam logic [4:0] OP_LEQ   = 5'd22;
  localparam logic [4:0] OP_GTR   = 5'd23;
  localparam logic [4:0] OP_GEQ   = 5'd24;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_DIV0  = 2'd1;
  localparam logic [1:0] FLT_STACK = 2'd2;
  localparam logic [1:0] FLT_JUMP  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_B, ST_RD_R, ST_EXEC, ST_WALK, ST_WALKW, ST_ADDR,
    ST_LODW, ST_CAL, ST_RTN3, ST_RTN4, ST_DIV, ST_DIVF, ST_WB, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLR, CMD_LOAD, CMD_RD_B, CMD_RD_R, CMD_EXEC, CMD_WALK,
    CMD_WALK_CAP, CMD_ADDR, CMD_LOD_WB, CMD_CAL, CMD_RTN3, CMD_RTN4,
    CMD_DIV_STEP, CMD_DIV_FIN, CMD_WB, CMD_OUT
  } cmd_t;

  typedef enum logic [3:0] {
    RT_DONE, RT_WB, RT_DIV, RT_WALK, RT_RTN, RT_STEP, RT_ADDR, RT_LOD, RT_CAL
  } route_t;

  typedef struct packed {
    logic   clr_done;
    logic   halted;
    logic   out_free;
    logic   last;
    route_t route;
  } sts_t;

endpackage

@@ rtl/core/rsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rsm_ctrl.sv @@
// Controller state machine: sequences clearing, operand reads, execution,
// static-link walks, calls, returns, division and result hand-off.
// Depends on rsm_pkg.
module rsm_ctrl
  import rsm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd = CMD_CLR;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd        = CMD_LOAD;
          state_next = sts.halted ? ST_OUT : ST_RD_B;
        end
      end
      ST_RD_B: begin
        cmd        = CMD_RD_B;
        state_next = ST_RD_R;
      end
      ST_RD_R: begin
        cmd        = CMD_RD_R;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd = CMD_EXEC;
        case (sts.route)
          RT_WB:   state_next = ST_WB;
          RT_DIV:  state_next = ST_DIV;
          RT_WALK: state_next = ST_WALK;
          RT_RTN:  state_next = ST_RTN3;
          default: state_next = ST_OUT;
        endcase
      end
      ST_WALK: begin
        cmd = CMD_WALK;
        case (sts.route)
          RT_STEP: state_next = ST_WALKW;
          RT_ADDR: state_next = ST_ADDR;
          default: state_next = ST_OUT;
        endcase
      end
      ST_WALKW: begin
        cmd        = CMD_WALK_CAP;
        state_next = ST_WALK;
      end
      ST_ADDR: begin
        cmd = CMD_ADDR;
        case (sts.route)
          RT_LOD:  state_next = ST_LODW;
          RT_CAL:  state_next = ST_CAL;
          default: state_next = ST_OUT;
        endcase
      end
      ST_LODW: begin
        cmd        = CMD_LOD_WB;
        state_next = ST_OUT;
      end
      ST_CAL: begin
        cmd = CMD_CAL;
        if (sts.last) state_next = ST_OUT;
      end
      ST_RTN3: begin
        cmd        = CMD_RTN3;
        state_next = ST_RTN4;
      end
      ST_RTN4: begin
        cmd        = CMD_RTN4;
        state_next = ST_OUT;
      end
      ST_DIV: begin
        cmd = CMD_DIV_STEP;
        if (sts.last) state_next = ST_DIVF;
      end
      ST_DIVF: begin
        cmd        = CMD_DIV_FIN;
        state_next = ST_WB;
      end
      ST_WB: begin
        cmd        = CMD_WB;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd        = CMD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // a result is only loaded when the output register can take it
  assert property (@(posedge clk) disable iff (rst) cmd == CMD_OUT |-> sts.out_free)
    else $error("result overwrites pending request");
  // a request is accepted only once clearing has finished
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> $past(state) != ST_CLEAR || $past(sts.clr_done))
    else $error("request accepted during clear");

endmodule

@@ rtl/core/rsm_dp.sv @@
// Datapath: register file and stack RAMs, PC/BP/SP, ALU, iterative divider,
// static-link walker and output register. Driven by rsm_ctrl commands.
// Depends on rsm_pkg and rsm_ram.
module rsm_dp
  import rsm_pkg::*;
#(
  parameter int STACK_DEPTH = 2048,
  parameter int NUM_REGS    = 16,
  parameter int CODE_DEPTH  = 512,
  localparam int SW = $clog2(STACK_DEPTH),
  localparam int RW = $clog2(NUM_REGS),
  localparam int CW = $clog2(CODE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic [4:0]    in_opcode,
  input  logic [3:0]    in_reg_sel,
  input  logic [3:0]    in_lev_or_src,
  input  logic [31:0]   in_m_operand,
  input  logic [31:0]   in_read_value,
  input  logic          m_tready,
  output logic          m_tvalid,
  output logic [CW-1:0] out_next_pc,
  output logic          out_write_valid,
  output logic [31:0]   out_write_value,
  output logic          out_halted,
  output logic [1:0]    out_fault
);

  localparam logic signed [33:0] SDEP = 34'(STACK_DEPTH);
  localparam logic signed [33:0] CDEP = 34'(CODE_DEPTH);

  function automatic logic in_rng(input logic signed [33:0] x, input logic signed [33:0] lim);
    return !x[33] && (x < lim);
  endfunction

  // instruction and operands
  logic [4:0]  op;
  logic [3:0]  rs, ls;
  logic [31:0] mo, rv, a, b, rr, res;
  logic signed [31:0] base;
  // architectural state
  logic [CW-1:0] pc;
  logic [SW-1:0] bp, sp, clr;
  logic          halt;
  // per-item result
  logic [1:0]  fault;
  logic        wvalid;
  logic [31:0] wval;
  logic [4:0]  cnt;
  // divider
  logic [31:0] dq, dd;
  logic [32:0] drem;
  logic        qneg, rneg;

  // RAM ports
  logic          rf_we, st_we;
  logic [RW-1:0] rf_wa, rf_ra;
  logic [SW-1:0] st_wa, st_ra;
  logic [31:0]   rf_wd, rf_rd, st_wd, st_rd;

  rsm_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd), .raddr(rf_ra), .rdata(rf_rd)
  );

  rsm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
  );

  logic        ls_ok, mreg_ok, rs_ok;
  logic [31:0] rr_now, alu, a_mag, b_mag;
  logic signed [33:0] ms34, base34, base_p1, ld_addr, inc_sp, sp_p4, bp_p3, nbp34, npc34;
  logic        m_code;
  logic [32:0] dtrial;
  logic [CW-1:0] pc_adv;

  always_comb begin
    ls_ok   = {1'b0, ls} < 5'(NUM_REGS);
    rs_ok   = {1'b0, rs} < 5'(NUM_REGS);
    mreg_ok = mo < 32'(NUM_REGS);
    rr_now  = rs_ok ? rf_rd : 32'd0;
    ms34    = {{2{mo[31]}}, mo};
    base34  = {{2{base[31]}}, base};
    base_p1 = base34 + 34'sd1;
    ld_addr = base34 + ms34;
    inc_sp  = 34'(sp) + ms34;
    sp_p4   = 34'(sp) + 34'sd4;
    bp_p3   = 34'(bp) + 34'sd3;
    nbp34   = {{2{base[31]}}, base};
    npc34   = {{2{st_rd[31]}}, st_rd};
    m_code  = in_rng(ms34, CDEP);
    a_mag   = a[31] ? 32'(-a) : a;
    b_mag   = b[31] ? 32'(-b) : b;
    dtrial  = {drem[31:0], dq[31]};
    pc_adv  = (pc == CW'(CODE_DEPTH - 1)) ? '0 : pc + 1'b1;
    case (op)
      OP_LIT:  alu = mo;
      OP_READ: alu = rv;
      OP_NEG:  alu = 32'(-a);
      OP_ADD:  alu = a + b;
      OP_SUB:  alu = a - b;
      OP_MUL:  alu = a * b;
      OP_ODD:  alu = {31'd0, rr_now[0]};
      OP_EQL:  alu = {31'd0, a == b};
      OP_NEQ:  alu = {31'd0, a != b};
      OP_LSS:  alu = {31'd0, $signed(a) <  $signed(b)};
      OP_LEQ:  alu = {31'd0, $signed(a) <= $signed(b)};
      OP_GTR:  alu = {31'd0, $signed(a) >  $signed(b)};
      OP_GEQ:  alu = {31'd0, $signed(a) >= $signed(b)};
      default: alu = 32'd0;
    endcase
  end

  // route back to the controller
  always_comb begin
    sts.clr_done = clr == SW'(STACK_DEPTH - 1);
    sts.halted   = halt;
    sts.out_free = !m_tvalid || m_tready;
    sts.last     = (cmd == CMD_CAL) ? (cnt == 5'd3) : (cnt == 5'd0);
    sts.route    = RT_DONE;
    case (cmd)
      CMD_EXEC: begin
        case (op)
          OP_LIT, OP_READ, OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_ODD,
          OP_EQL, OP_NEQ, OP_LSS, OP_LEQ, OP_GTR, OP_GEQ: sts.route = RT_WB;
          OP_DIV, OP_MOD: sts.route = (b == 32'd0) ? RT_DONE : RT_DIV;
          OP_LOD, OP_STO, OP_CAL: sts.route = RT_WALK;
          OP_RTN: sts.route = (bp != '0 && in_rng(bp_p3, SDEP)) ? RT_RTN : RT_DONE;
          default: sts.route = RT_DONE;
        endcase
      end
      CMD_WALK: begin
        if (cnt == 5'd0) sts.route = RT_ADDR;
        else if (in_rng(base_p1, SDEP)) sts.route = RT_STEP;
        else sts.route = RT_DONE;
      end
      CMD_ADDR: begin
        if (op == OP_LOD && in_rng(ld_addr, SDEP)) sts.route = RT_LOD;
        else if (op == OP_CAL && in_rng(sp_p4, SDEP) && m_code) sts.route = RT_CAL;
        else sts.route = RT_DONE;
      end
      default: sts.route = RT_DONE;
    endcase
  end

  // RAM port steering
  always_comb begin
    rf_we = 1'b0;
    rf_wa = rs[RW-1:0];
    rf_wd = res;
    rf_ra = rs[RW-1:0];
    st_we = 1'b0;
    st_wa = ld_addr[SW-1:0];
    st_wd = rr;
    st_ra = '0;
    case (cmd)
      CMD_CLR: begin
        rf_we = 32'(clr) < 32'(NUM_REGS);
        rf_wa = clr[RW-1:0];
        rf_wd = 32'd0;
        st_we = 1'b1;
        st_wa = clr;
        st_wd = 32'd0;
      end
      CMD_LOAD: rf_ra = in_lev_or_src[RW-1:0];
      CMD_RD_B: rf_ra = mo[RW-1:0];
      CMD_RD_R: rf_ra = rs[RW-1:0];
      CMD_EXEC: st_ra = bp_p3[SW-1:0] - 1'b1;
      CMD_WALK: st_ra = base_p1[SW-1:0];
      CMD_ADDR: begin
        st_ra = ld_addr[SW-1:0];
        st_we = (op == OP_STO) && in_rng(ld_addr, SDEP);
      end
      CMD_RTN3: st_ra = bp_p3[SW-1:0];
      CMD_LOD_WB: begin
        rf_we = rs_ok;
        rf_wd = st_rd;
      end
      CMD_WB: rf_we = rs_ok;
      CMD_CAL: begin
        st_we = 1'b1;
        st_wa = sp + SW'(cnt) + 1'b1;
        case (cnt[1:0])
          2'd0:    st_wd = 32'd0;
          2'd1:    st_wd = base;
          2'd2:    st_wd = 32'(bp);
          default: st_wd = 32'(pc);
        endcase
      end
      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      bp       <= SW'(1);
      sp       <= '0;
      halt     <= 1'b0;
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && cmd != CMD_OUT) m_tvalid <= 1'b0;
      case (cmd)
        CMD_CLR:  clr <= clr + 1'b1;
        CMD_LOAD: if (!halt) pc <= pc_adv;
        CMD_EXEC: begin
          case (op)
            OP_JMP: if (m_code) pc <= mo[CW-1:0];
            OP_JPC: if (rr_now == 32'd0 && m_code) pc <= mo[CW-1:0];
            OP_HALT: halt <= 1'b1;
            OP_INC: if (in_rng(inc_sp, SDEP)) sp <= inc_sp[SW-1:0];
            default: ;
          endcase
        end
        CMD_CAL: begin
          if (cnt == 5'd3) begin
            bp <= sp + 1'b1;
            pc <= mo[CW-1:0];
          end
        end
        CMD_RTN4: begin
          if (in_rng(nbp34, SDEP) && in_rng(npc34, CDEP)) begin
            sp <= bp - 1'b1;
            bp <= base[SW-1:0];
            pc <= st_rd[CW-1:0];
          end
        end
        CMD_OUT: m_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op     <= in_opcode;
        rs     <= in_reg_sel;
        ls     <= in_lev_or_src;
        mo     <= in_m_operand;
        rv     <= in_read_value;
        fault  <= FLT_NONE;
        wvalid <= 1'b0;
        wval   <= 32'd0;
      end
      CMD_RD_B: a <= ls_ok ? rf_rd : 32'd0;
      CMD_RD_R: b <= mreg_ok ? rf_rd : 32'd0;
      CMD_EXEC: begin
        rr  <= rr_now;
        res <= alu;
        case (op)
          OP_DIV, OP_MOD: begin
            if (b == 32'd0) begin
              fault <= FLT_DIV0;
            end else begin
              dq   <= a_mag;
              dd   <= b_mag;
              drem <= '0;
              qneg <= a[31] ^ b[31];
              rneg <= a[31];
              cnt  <= 5'd31;
            end
          end
          OP_JMP: if (!m_code) fault <= FLT_JUMP;
          OP_JPC: if (rr_now == 32'd0 && !m_code) fault <= FLT_JUMP;
          OP_WRITE: begin
            wvalid <= 1'b1;
            wval   <= rr_now;
          end
          OP_INC: if (!in_rng(inc_sp, SDEP)) fault <= FLT_STACK;
          OP_LOD, OP_STO, OP_CAL: begin
            base <= $signed(32'(bp));
            cnt  <= {1'b0, ls};
          end
          OP_RTN: if (bp == '0 || !in_rng(bp_p3, SDEP)) fault <= FLT_STACK;
          default: ;
        endcase
      end
      CMD_WALK: begin
        if (cnt != 5'd0) begin
          if (in_rng(base_p1, SDEP)) cnt <= cnt - 1'b1;
          else fault <= FLT_STACK;
        end
      end
      CMD_WALK_CAP: base <= $signed(st_rd);
      CMD_ADDR: begin
        cnt <= 5'd0;
        if (op == OP_CAL) begin
          if (!in_rng(sp_p4, SDEP)) fault <= FLT_STACK;
          else if (!m_code) fault <= FLT_JUMP;
        end else if (!in_rng(ld_addr, SDEP)) begin
          fault <= FLT_STACK;
        end
      end
      CMD_CAL: cnt <= cnt + 1'b1;
      CMD_RTN3: base <= $signed(st_rd);
      CMD_RTN4: begin
        if (!in_rng(nbp34, SDEP)) fault <= FLT_STACK;
        else if (!in_rng(npc34, CDEP)) fault <= FLT_JUMP;
      end
      CMD_DIV_STEP: begin
        cnt <= cnt - 1'b1;
        if (dtrial >= {1'b0, dd}) begin
          drem <= dtrial - {1'b0, dd};
          dq   <= {dq[30:0], 1'b1};
        end else begin
          drem <= dtrial;
          dq   <= {dq[30:0], 1'b0};
        end
      end
      CMD_DIV_FIN: begin
        if (op == OP_DIV) res <= qneg ? 32'(-dq) : dq;
        else res <= rneg ? 32'(-drem[31:0]) : drem[31:0];
      end
      CMD_OUT: begin
        out_next_pc     <= pc;
        out_write_valid <= wvalid;
        out_write_value <= wval;
        out_halted      <= halt;
        out_fault       <= fault;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) !$fell(halt))
    else $error("halt flag cleared outside reset");
  assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_OUT && fault == FLT_DIV0) |-> (op == OP_DIV || op == OP_MOD))
    else $error("divide fault on a non-divide opcode");
  assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_OUT && wvalid) |-> (op == OP_WRITE && fault == FLT_NONE))
    else $error("write output from wrong opcode");

endmodule

@@ rtl/core/register_stack_machine_exec.sv @@
// Register stack machine executor: one instruction per input request.
// Top level joining rsm_ctrl and rsm_dp. Depends on rsm_pkg.
//
//  s_* carries one instruction per request; the fetcher supplies the
//  instruction at the next_pc of the previous result (0 after reset).
//  m_* returns one result per instruction: next PC, write output, halt
//  flag and fault code.
//  Divide and modulo run 32 one-bit divider steps; once halted, a request
//  goes straight to the result without executing. One instruction is in
//  flight at a time; the next request can be accepted in the cycle after
//  a result is loaded.
//  Reset: a clearing pass writes zero through the stack memory (STACK_DEPTH
//  words, 2048 by default) and the registers; s_tready stays low
//  meanwhile.
//  When the receiver stalls the finished result waits in the output
//  register; the next instruction is accepted and executed, and its result
//  waits until the held one is taken.
module register_stack_machine_exec
  import rsm_pkg::*;
#(
  parameter int STACK_DEPTH = 2048,
  parameter int NUM_REGS    = 16,
  parameter int CODE_DEPTH  = 512,
  localparam int CW    = $clog2(CODE_DEPTH),
  localparam int OUT_W = ((CW + 36 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // opcode[4:0], reg_sel[8:5], lev_or_src[12:9], m_operand[44:13],
  // read_value[76:45], zero fill
  input  logic [79:0]      s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // next_pc, write_valid, write_value, halted, fault, zero fill
  output logic [OUT_W-1:0] m_tdata
);

  cmd_t cmd;
  sts_t sts;

  logic [CW-1:0] next_pc;
  logic          write_valid, halted;
  logic [31:0]   write_value;
  logic [1:0]    fault;

  rsm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .sts(sts), .cmd(cmd)
  );

  rsm_dp #(
    .STACK_DEPTH(STACK_DEPTH), .NUM_REGS(NUM_REGS), .CODE_DEPTH(CODE_DEPTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_opcode(s_tdata[4:0]), .in_reg_sel(s_tdata[8:5]), .in_lev_or_src(s_tdata[12:9]),
    .in_m_operand(s_tdata[44:13]), .in_read_value(s_tdata[76:45]),
    .m_tready(m_tready), .m_tvalid(m_tvalid),
    .out_next_pc(next_pc), .out_write_valid(write_valid), .out_write_value(write_value),
    .out_halted(halted), .out_fault(fault)
  );

  assign m_tdata = OUT_W'({fault, halted, write_value, write_valid, next_pc});

endmodule

@@ tb/tb.sv @@
// Self-checking bench for register_stack_machine_exec: directed rows, then random
// programs checked against an in-bench model of the register machine.
// Depends on rsm_pkg and the RTL of the block only.
module tb
  import rsm_pkg::*;
();

  localparam int SDEPTH = 2048;
  localparam int CDEPTH = 512;
  localparam int NREGS  = 16;
  localparam int QUIET_LIMIT = 8000;

  // from the lowest bit up: pc, wvalid, wvalue, halted, flt
  typedef struct packed {
    logic [1:0]  flt;
    logic        halted;
    logic [31:0] wvalue;
    logic        wvalid;
    logic [8:0]  pc;
  } res_t;

  typedef struct {
    logic [4:0]  op;
    logic [3:0]  r;
    logic [3:0]  l;
    logic [31:0] m;
    logic [31:0] rv;
    bit          fixed;
    res_t        want;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;

  register_stack_machine_exec DUT (.*);

  always #2 clk = ~clk;

  // machine state as the bench sees it
  logic [31:0] regs [NREGS];
  logic [31:0] stk [SDEPTH];
  int unsigned pc_q, bp_q, sp_q;
  bit          halt_q;

  res_t pending [$];
  int   errors, n_sent, n_got, n_writes, n_faults, quiet;
  bit   tx_done, hold_rx;

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint rd(longint unsigned i);
    return i < NREGS ? sx(regs[i]) : 64'sd0;
  endfunction

  function automatic void wr(longint unsigned i, longint v);
    if (i < NREGS) regs[i] = v[31:0];
  endfunction

  function automatic bit in_stk(longint a);
    return a >= 0 && a < SDEPTH;
  endfunction

  function automatic bit in_code(longint a);
    return a >= 0 && a < CDEPTH;
  endfunction

  function automatic bit follow_links(int lev, output longint base);
    longint b;
    b = longint'(bp_q);
    base = 0;
    for (int k = 0; k < lev; k++) begin
      if (!in_stk(b + 1)) return 1'b0;
      b = sx(stk[b + 1]);
    end
    base = b;
    return 1'b1;
  endfunction

  function automatic res_t run_instr(logic [4:0] op, logic [3:0] r, logic [3:0] l,
                                     logic [31:0] mw, logic [31:0] rvw);
    res_t   o;
    longint m, a, b, base, addr, sp, nbp, npc;
    m = sx(mw);
    a = rd(64'(l));
    b = rd({32'd0, mw});
    o = '0;
    if (!halt_q) begin
      pc_q = (pc_q + 1) % CDEPTH;
      case (op)
        OP_LIT: wr(64'(r), m);
        OP_RTN: begin
          sp = longint'(bp_q) - 1;
          if (sp < 0 || !in_stk(sp + 4)) o.flt = FLT_STACK;
          else begin
            nbp = sx(stk[sp + 3]);
            npc = sx(stk[sp + 4]);
            if (!in_stk(nbp)) o.flt = FLT_STACK;
            else if (!in_code(npc)) o.flt = FLT_JUMP;
            else begin
              sp_q = 32'(sp); bp_q = 32'(nbp); pc_q = 32'(npc);
            end
          end
        end
        OP_LOD, OP_STO: begin
          if (!follow_links(int'(l), base)) o.flt = FLT_STACK;
          else begin
            addr = base + m;
            if (!in_stk(addr)) o.flt = FLT_STACK;
            else if (op == OP_LOD) wr(64'(r), sx(stk[addr]));
            else stk[addr] = 32'(rd(64'(r)));
          end
        end
        OP_CAL: begin
          sp = longint'(sp_q);
          if (!follow_links(int'(l), base) || !in_stk(sp + 4)) o.flt = FLT_STACK;
          else if (!in_code(m)) o.flt = FLT_JUMP;
          else begin
            stk[sp + 1] = 32'd0;
            stk[sp + 2] = base[31:0];
            stk[sp + 3] = bp_q;
            stk[sp + 4] = pc_q;
            bp_q = 32'(sp + 1);
            pc_q = 32'(m);
          end
        end
        OP_INC: begin
          addr = longint'(sp_q) + m;
          if (!in_stk(addr)) o.flt = FLT_STACK;
          else sp_q = 32'(addr);
        end
        OP_JMP: if (!in_code(m)) o.flt = FLT_JUMP; else pc_q = 32'(m);
        OP_JPC: if (rd(64'(r)) == 0) begin
          if (!in_code(m)) o.flt = FLT_JUMP; else pc_q = 32'(m);
        end
        OP_WRITE: begin
          o.wvalid = 1'b1;
          o.wvalue = 32'(rd(64'(r)));
        end
        OP_READ: wr(64'(r), sx(rvw));
        OP_HALT: halt_q = 1'b1;
        OP_NEG:  wr(64'(r), -a);
        OP_ADD:  wr(64'(r), a + b);
        OP_SUB:  wr(64'(r), a - b);
        OP_MUL:  wr(64'(r), a * b);
        OP_DIV:  if (b == 0) o.flt = FLT_DIV0; else wr(64'(r), a / b);
        OP_ODD:  wr(64'(r), rd(64'(r)) & 64'sd1);
        OP_MOD:  if (b == 0) o.flt = FLT_DIV0; else wr(64'(r), a % b);
        OP_EQL:  wr(64'(r), longint'(a == b));
        OP_NEQ:  wr(64'(r), longint'(a != b));
        OP_LSS:  wr(64'(r), longint'(a < b));
        OP_LEQ:  wr(64'(r), longint'(a <= b));
        OP_GTR:  wr(64'(r), longint'(a > b));
        OP_GEQ:  wr(64'(r), longint'(a >= b));
        default: ;
      endcase
    end
    o.pc = pc_q[8:0];
    o.halted = halt_q;
    return o;
  endfunction

  function automatic res_t mk(logic [8:0] pc, logic [1:0] flt);
    res_t o;
    o = '0;
    o.pc = pc;
    o.flt = flt;
    return o;
  endfunction

  task automatic report(string what, res_t got, res_t want);
    errors++;
    $display("mismatch %s at result %0d: got pc=%0d wv=%0b val=%h h=%0b f=%0d, %s",
             what, n_got, got.pc, got.wvalid, got.wvalue, got.halted, got.flt,
             $sformatf("want pc=%0d wv=%0b val=%h h=%0b f=%0d",
                       want.pc, want.wvalid, want.wvalue, want.halted, want.flt));
  endtask

  // one request on the input side; model is stepped at acceptance
  task automatic send(logic [4:0] op, logic [3:0] r, logic [3:0] l, logic [31:0] m,
                      logic [31:0] rv, bit fixed, res_t want, bit may_idle);
    res_t p;
    while (may_idle && $urandom_range(99) < 32) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {3'b0, rv, m, l, r, op};
    do @(posedge clk); while (!s_tready);
    p = run_instr(op, r, l, m, rv);
    pending.push_back(fixed ? want : p);
    n_sent++;
  endtask

  task automatic send_random(bit may_idle);
    logic [4:0]  op;
    logic [3:0]  l;
    logic [31:0] m;
    int k;
    k = $urandom_range(99);
    l = 4'($urandom_range(15));
    m = $urandom;
    if (k < 4) op = $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 25));
    else if (k < 14) begin
      op = OP_LIT;
      if ($urandom_range(1)) m = $urandom_range(20);
    end else if (k < 30) begin
      op = $urandom_range(1) ? OP_LOD : OP_STO;
      l = $urandom_range(3) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(2));
      if ($urandom_range(7)) m = $urandom_range(40);
    end else if (k < 36) begin
      op = OP_CAL;
      l = 4'($urandom_range(2));
      if ($urandom_range(7)) m = $urandom_range(CDEPTH - 1);
    end else if (k < 41) op = OP_RTN;
    else if (k < 47) begin
      op = OP_INC;
      if ($urandom_range(7)) m = $urandom_range(16) - 8;
    end else if (k < 54) begin
      op = $urandom_range(1) ? OP_JMP : OP_JPC;
      if ($urandom_range(5)) m = $urandom_range(CDEPTH - 1);
    end else if (k < 62) op = $urandom_range(1) ? OP_WRITE : OP_READ;
    else begin
      op = 5'($urandom_range(24, 12));
      if ($urandom_range(4)) m = $urandom_range(15);
      else if ($urandom_range(1)) m = 0;
    end
    send(op, 4'($urandom_range(15)), l, m, $urandom, 1'b0, '0, may_idle);
  endtask

  row_t rows [] = '{
    '{OP_LIT,   4'd1,  4'd0,  32'd7,        32'd0, 1'b1, mk(9'd1, FLT_NONE)},
    '{OP_DIV,   4'd2,  4'd1,  32'd0,        32'd0, 1'b1, mk(9'd2, FLT_DIV0)},
    '{OP_JMP,   4'd0,  4'd0,  32'd512,      32'd0, 1'b1, mk(9'd3, FLT_JUMP)},
    '{OP_JMP,   4'd0,  4'd0,  32'hffffffff, 32'd0, 1'b1, mk(9'd4, FLT_JUMP)},
    '{OP_INC,   4'd0,  4'd0,  32'hffffffff, 32'd0, 1'b1, mk(9'd5, FLT_STACK)},
    '{OP_MOD,   4'd2,  4'd1,  32'd0,        32'd0, 1'b1, mk(9'd6, FLT_DIV0)},
    '{OP_LIT,   4'd3,  4'd0,  32'h7fffffff, 32'd0, 1'b0, '0},
    '{OP_LIT,   4'd4,  4'd0,  32'h80000000, 32'd0, 1'b0, '0},
    '{OP_LIT,   4'd5,  4'd0,  32'hffffffff, 32'd0, 1'b0, '0},
    '{OP_DIV,   4'd6,  4'd4,  32'd5,        32'd0, 1'b0, '0},
    '{OP_MOD,   4'd7,  4'd4,  32'd5,        32'd0, 1'b0, '0},
    '{OP_ADD,   4'd8,  4'd3,  32'd3,        32'd0, 1'b0, '0},
    '{OP_MUL,   4'd9,  4'd3,  32'd4,        32'd0, 1'b0, '0},
    '{OP_SUB,   4'd10, 4'd4,  32'd3,        32'd0, 1'b0, '0},
    '{OP_NEG,   4'd11, 4'd4,  32'd0,        32'd0, 1'b0, '0},
    '{OP_ODD,   4'd5,  4'd0,  32'd0,        32'd0, 1'b0, '0},
    '{OP_ADD,   4'd12, 4'd3,  32'd100,      32'd0, 1'b0, '0},
    '{OP_READ,  4'd15, 4'd0,  32'd0, 32'h80000000, 1'b0, '0},
    '{OP_WRITE, 4'd15, 4'd0,  32'd0,        32'd0, 1'b0, '0},
    '{OP_JPC,   4'd0,  4'd0,  32'd10,       32'd0, 1'b0, '0},
    '{OP_JPC,   4'd1,  4'd0,  32'd999,      32'd0, 1'b0, '0},
    '{OP_CAL,   4'd0,  4'd0,  32'd20,       32'd0, 1'b0, '0},
    '{OP_STO,   4'd3,  4'd15, 32'd2047,     32'd0, 1'b0, '0},
    '{OP_LOD,   4'd13, 4'd1,  32'd0,        32'd0, 1'b0, '0},
    '{OP_RTN,   4'd0,  4'd0,  32'd0,        32'd0, 1'b0, '0}
  };

  initial begin
    for (int i = 0; i < NREGS; i++) regs[i] = 0;
    for (int i = 0; i < SDEPTH; i++) stk[i] = 0;
    pc_q = 0; bp_q = 1; sp_q = 0; halt_q = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    foreach (rows[i])
      send(rows[i].op, rows[i].r, rows[i].l, rows[i].m, rows[i].rv,
           rows[i].fixed, rows[i].want, 1'b1);
    // the six compare opcodes on a single operand pair
    for (int i = 0; i < 6; i++)
      send(5'(OP_EQL + i), 4'd14, 4'd4, 32'd3, 32'd0, 1'b0, '0, 1'b1);
    for (int i = 0; i < 880; i++) send_random(i < 300 || i > 450);
    send(OP_HALT, 4'd0, 4'd0, 32'd0, 32'd0, 1'b0, '0, 1'b1);
    repeat (3) send_random(1'b1);
    s_tvalid <= 0;
    tx_done = 1'b1;
  end

  // receiver: random back-pressure, one long hold-off, and a window of steady readiness
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!hold_rx && n_got == 200) begin
        hold_rx = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 0;
      end else if (n_sent > 350 && n_sent < 500)
        m_tready <= 1;
      else
        m_tready <= $urandom_range(99) >= 32;
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (m_tvalid && m_tready) begin
      got = m_tdata[44:0];
      n_got++;
      if (got.wvalid) n_writes++;
      if (got.flt != FLT_NONE) n_faults++;
      if (pending.size() == 0) report("unexpected", got, '0);
      else begin
        want = pending.pop_front();
        if (got.pc != want.pc) report("next_pc", got, want);
        if (got.wvalid != want.wvalid) report("write_valid", got, want);
        if (got.wvalue != want.wvalue) report("write_value", got, want);
        if (got.halted != want.halted) report("halted", got, want);
        if (got.flt != want.flt) report("fault", got, want);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout with %0d requests outstanding", pending.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    wait (tx_done);
    wait (pending.size() == 0);
    repeat (60) @(posedge clk);
    $display("ran %0d requests, %0d results, %0d writes, %0d faults, ended halted",
             n_sent, n_got, n_writes, n_faults);
    if (errors == 0 && pending.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rsm_pkg.sv
rtl/core/rsm_ram.sv
rtl/core/rsm_ctrl.sv
rtl/core/rsm_dp.sv
rtl/core/register_stack_machine_exec.sv
tb/tb.sv
